// ----- rtl/core/mtfc_pkg.sv -----
package mtfc_pkg;

    localparam int SYM_W             = 8;
    localparam int ALPHABET_SIZE_DEF = 256;

    typedef enum logic {
        DIR_FWD = 1'b0,
        DIR_INV = 1'b1
    } t_dir;

    // token travelling down the cell chain
    typedef struct packed {
        logic             vld;
        logic             done;
        logic [SYM_W-1:0] carry;
        logic [SYM_W-1:0] pos;
    } t_tok;

endpackage

// ----- rtl/core/mtfc_cell.sv -----
module mtfc_cell #(
    parameter int IDX = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mtfc_pkg::t_dir           i_dir,
    input  logic [mtfc_pkg::SYM_W-1:0] i_key,
    input  logic                     i_front_we,
    input  logic [mtfc_pkg::SYM_W-1:0] i_front_sym,
    input  mtfc_pkg::t_tok           i_tok,
    output mtfc_pkg::t_tok           o_tok
);

    localparam logic [mtfc_pkg::SYM_W-1:0] MY_POS = mtfc_pkg::SYM_W'(IDX);

    logic [mtfc_pkg::SYM_W-1:0] r_sym;
    logic [mtfc_pkg::SYM_W-1:0] n_sym;
    mtfc_pkg::t_tok             r_tok;
    mtfc_pkg::t_tok             n_tok;
    logic                       w_hit;
    logic                       w_work;

    assign w_hit  = (i_dir == mtfc_pkg::DIR_FWD) ? (r_sym == i_key) : (MY_POS == i_key);
    assign w_work = i_tok.vld && !i_tok.done;

    always_comb begin
        n_sym = r_sym;
        n_tok = i_tok;
        if (w_work) begin
            n_tok.carry = r_sym;
            if (w_hit) begin
                n_tok.done = 1'b1;
                n_tok.pos  = MY_POS;
            end
            // front cell is refilled once the found symbol is known
            if (IDX > 0) begin
                n_sym = i_tok.carry;
            end
        end
        if (IDX == 0 && i_front_we) begin
            n_sym = i_front_sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym     <= MY_POS;
            r_tok.vld <= 1'b0;
        end else begin
            r_sym     <= n_sym;
            r_tok.vld <= n_tok.vld;
        end
        r_tok.done  <= n_tok.done;
        r_tok.carry <= n_tok.carry;
        r_tok.pos   <= n_tok.pos;
    end

    assign o_tok = r_tok;

endmodule

// ----- rtl/core/move_to_front_coder_core.sv -----
// Byte move-to-front coder. Each cell of a row of ALPHABET_SIZE cells holds the symbol at
// one list position. An accepted byte sends a token down the row, one cell per cycle,
// shifting entries back by one until the symbol (forward) or the position (inverse) is
// found; the token then runs on to the end of the row carrying the result. One byte is in
// work at a time: the next byte is accepted only after the token of the previous one has
// left the row and while the skid is empty. The result register and a one-entry skid let
// the next byte be accepted while a result still waits. Direction is set by i_cfg_wdata
// (0 forward, 1 inverse); the user must see that it is written only while the coder is
// idle, as the block itself does not enforce this. Reset restores identity order.
module move_to_front_coder_core #(
    parameter int ALPHABET_SIZE = mtfc_pkg::ALPHABET_SIZE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_wdata,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [mtfc_pkg::SYM_W-1:0] i_s_axis_tdata,   // [7:0] in_byte
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [mtfc_pkg::SYM_W-1:0] o_m_axis_tdata    // [7:0] out_byte
);

    localparam logic [mtfc_pkg::SYM_W:0] TOP_IDX = (mtfc_pkg::SYM_W + 1)'(ALPHABET_SIZE - 1);

    mtfc_pkg::t_tok             w_tok [ALPHABET_SIZE+1];
    mtfc_pkg::t_tok             w_exit;
    mtfc_pkg::t_dir             r_dir;
    logic [mtfc_pkg::SYM_W-1:0] r_key;
    logic [mtfc_pkg::SYM_W-1:0] n_key;
    logic                       r_busy, n_busy;
    logic                       r_start, n_start;
    logic                       r_oval, n_oval;
    logic [mtfc_pkg::SYM_W-1:0] r_odata, n_odata;
    logic                       r_pval, n_pval;
    logic [mtfc_pkg::SYM_W-1:0] r_pdata, n_pdata;
    logic                       w_acc;
    logic [mtfc_pkg::SYM_W-1:0] w_res;

    assign o_s_axis_tready = !r_busy && !r_pval;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_exit          = w_tok[ALPHABET_SIZE];
    assign w_res           = (r_dir == mtfc_pkg::DIR_FWD) ? w_exit.pos : w_exit.carry;

    always_comb begin
        w_tok[0]       = '0;
        w_tok[0].vld   = r_start;
    end

    for (genvar k = 0; k < ALPHABET_SIZE; k++) begin : g_cell
        mtfc_cell #(
            .IDX(k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_dir       (r_dir),
            .i_key       (r_key),
            .i_front_we  ((k == 0) && w_exit.vld),
            .i_front_sym (w_exit.carry),
            .i_tok       (w_tok[k]),
            .o_tok       (w_tok[k+1])
        );
    end

    always_comb begin
        n_key   = r_key;
        n_busy  = r_busy;
        n_start = 1'b0;
        n_oval  = r_oval;
        n_odata = r_odata;
        n_pval  = r_pval;
        n_pdata = r_pdata;
        if (w_acc) begin
            // out-of-range input saturates to the last list entry
            if ({1'b0, i_s_axis_tdata} > TOP_IDX) begin
                n_key = TOP_IDX[mtfc_pkg::SYM_W-1:0];
            end else begin
                n_key = i_s_axis_tdata;
            end
            n_busy  = 1'b1;
            n_start = 1'b1;
        end
        if (w_exit.vld) begin
            n_busy = 1'b0;
            if (!r_oval || i_m_axis_tready) begin
                n_oval  = 1'b1;
                n_odata = w_res;
            end else begin
                n_pval  = 1'b1;
                n_pdata = w_res;
            end
        end else if (r_oval && i_m_axis_tready) begin
            if (r_pval) begin
                n_odata = r_pdata;
                n_pval  = 1'b0;
            end else begin
                n_oval = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= mtfc_pkg::DIR_FWD;
            r_busy  <= 1'b0;
            r_start <= 1'b0;
            r_oval  <= 1'b0;
            r_pval  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dir <= mtfc_pkg::t_dir'(i_cfg_wdata);
            end
            r_busy  <= n_busy;
            r_start <= n_start;
            r_oval  <= n_oval;
            r_pval  <= n_pval;
        end
        r_key   <= n_key;
        r_odata <= n_odata;
        r_pdata <= n_pdata;
    end

    assign o_m_axis_tvalid = r_oval;
    assign o_m_axis_tdata  = r_odata;

    a_exit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.vld |-> w_exit.done)
        else $error("token left the cell row without a match");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.vld |-> r_busy && !r_start)
        else $error("token exit without an item in work");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pval |-> r_oval)
        else $error("skid entry held while result register empty");

    a_no_exit_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pval |-> !w_exit.vld)
        else $error("result arrived with both output entries full");

endmodule
